>>> hw/rtl/npa_pkg.sv
// ============================================================================
// npa_pkg: shared codes for the node pool allocator
// Operation and status codes carried on the request and response beats.
// ============================================================================
`default_nettype none

package npa_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   // operation codes
   localparam mode_type MODE_ALLOC   = 2'd0;
   localparam mode_type MODE_RELEASE = 2'd1;
   localparam mode_type MODE_DISCARD = 2'd2;
   localparam mode_type MODE_COMMIT  = 2'd3;

   // response status codes
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_NO_IDLE = 2'd1;
   localparam status_type STATUS_BAD_IDX = 2'd2;

endpackage : npa_pkg

`default_nettype wire

>>> hw/rtl/node_pool_mark_release_allocator_core.sv
// ============================================================================
// node_pool_mark_release_allocator_core: node pool allocator, mark/release
// Pool of nodes on one doubly linked chain behind a sentinel (index 0), with
// a committed mark and an idle head; allocate, release, discard and commit.
// ============================================================================
// Sequencing: allocate, discard, commit and rejected beats go IDLE, READ, then
// load the response; release goes IDLE, READ, LINK (read at acceptance, two link writes).
// Throughput: one request at a time, the pace set by a free response register, the
// registered link read and, for release, two writes into each single-write link memory.
// Reset: a clearing pass over the POOL_NODES+1 link entries rebuilds the initial chain;
// req_ready stays low until it completes.
`default_nettype none

module node_pool_mark_release_allocator_core
   import npa_pkg::*;
#(
   parameter int POOL_NODES = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [1:0]                           req_mode,
   input  wire  [$clog2(POOL_NODES + 2) - 1:0]  req_node,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [$clog2(POOL_NODES + 2) - 1:0]  rsp_granted_node,
   output logic [1:0]                           rsp_status
);

   // index width covers nodes 0..POOL_NODES plus the "none" code
   localparam int IDX_W = $clog2(POOL_NODES + 2);
   // address width of the link memories (POOL_NODES+1 entries)
   localparam int AW    = $clog2(POOL_NODES + 1);
   localparam int DEPTH = POOL_NODES + 1;

   localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(POOL_NODES);
   localparam logic [IDX_W-1:0] NONE_IDX  = IDX_W'(POOL_NODES + 1);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(POOL_NODES);

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;  // rebuilding chain after reset
   localparam logic [1:0] ST_IDLE  = 2'd1;  // waiting for a request beat
   localparam logic [1:0] ST_READ  = 2'd2;  // link read data available
   localparam logic [1:0] ST_LINK  = 2'd3;  // second pair of release writes

   // ------------------------------------------------------------------------
   // link memories: one write port and one registered read port each
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0] next_mem [DEPTH];
   logic [IDX_W-1:0] prev_mem [DEPTH];

   logic             next_we;
   logic [AW-1:0]    next_wa;
   logic [IDX_W-1:0] next_wd;
   logic             prev_we;
   logic [AW-1:0]    prev_wa;
   logic [IDX_W-1:0] prev_wd;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [IDX_W-1:0] next_rd_ff;
   logic [IDX_W-1:0] prev_rd_ff;

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (rd_en) begin
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (rd_en) begin
         prev_rd_ff <= prev_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // control and pointer registers
   // ------------------------------------------------------------------------
   logic [1:0]       state_ff,  state_in;
   logic [AW-1:0]    clr_ff,    clr_in;
   logic [IDX_W-1:0] idle_ff,   idle_in;    // first idle node
   logic [IDX_W-1:0] mark_ff,   mark_in;    // last committed node
   logic             rsp_valid_ff, rsp_valid_in;

   // payload held for the beat in flight and the response register
   mode_type         op_ff,     op_in;
   logic [IDX_W-1:0] node_ff,   node_in;
   status_type       err_ff,    err_in;     // verdict decided at acceptance
   logic [IDX_W-1:0] granted_ff, granted_in;
   status_type       status_ff, status_in;

   logic accept;
   logic out_free;
   logic idle_ok;
   logic mark_ok;
   logic finish;

   assign idle_ok  = (idle_ff <= LAST_NODE);
   assign mark_ok  = (mark_ff <= LAST_NODE);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept   = req_valid && req_ready;
   // response register can take a new beat this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_node = granted_ff;
   assign rsp_status       = status_ff;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      idle_in    = idle_ff;
      mark_in    = mark_ff;
      op_in      = op_ff;
      node_in    = node_ff;
      err_in     = err_ff;
      granted_in = granted_ff;
      status_in  = status_ff;
      finish     = 1'b0;

      next_we = 1'b0;
      next_wa = '0;
      next_wd = NONE_IDX;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = NONE_IDX;
      rd_en   = 1'b0;
      rd_addr = '0;

      case (state_ff)
         ST_CLEAR: begin
            // initial chain: next = i+1, prev = i-1, ends point to none
            next_we = 1'b1;
            next_wa = clr_ff;
            next_wd = (clr_ff == LAST_ADDR) ? NONE_IDX : IDX_W'(clr_ff) + 1'b1;
            prev_we = 1'b1;
            prev_wa = clr_ff;
            prev_wd = (clr_ff == '0) ? NONE_IDX : IDX_W'(clr_ff) - 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in   = req_mode;
               node_in = req_node;
               err_in  = STATUS_OK;
               case (req_mode)
                  MODE_ALLOC: begin
                     if (!idle_ok) err_in = STATUS_NO_IDLE;
                  end
                  MODE_RELEASE: begin
                     // bad index takes priority over a missing idle head
                     if (req_node == '0 || req_node > LAST_NODE) begin
                        err_in = STATUS_BAD_IDX;
                     end else if (!idle_ok) begin
                        err_in = STATUS_NO_IDLE;
                     end
                  end
                  MODE_DISCARD: begin
                     err_in = STATUS_OK;
                  end
                  MODE_COMMIT: begin
                     if (!idle_ok) err_in = STATUS_NO_IDLE;
                  end
                  default: begin
                     err_in = STATUS_OK;
                  end
               endcase
               // discard reads the mark's successor, the rest the idle head
               if (req_mode == MODE_DISCARD) begin
                  rd_en   = mark_ok;
                  rd_addr = mark_ff[AW-1:0];
               end else begin
                  rd_en   = idle_ok;
                  rd_addr = idle_ff[AW-1:0];
               end
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            if (err_ff != STATUS_OK) begin
               if (out_free) begin
                  finish     = 1'b1;
                  granted_in = NONE_IDX;
                  status_in  = err_ff;
               end
            end else if (op_ff == MODE_RELEASE) begin
               // first pair: next[node] = after, prev[node] = idle head
               next_we  = 1'b1;
               next_wa  = node_ff[AW-1:0];
               next_wd  = next_rd_ff;
               prev_we  = 1'b1;
               prev_wa  = node_ff[AW-1:0];
               prev_wd  = idle_ff;
               state_in = ST_LINK;
            end else if (out_free) begin
               finish     = 1'b1;
               granted_in = NONE_IDX;
               status_in  = STATUS_OK;
               case (op_ff)
                  MODE_ALLOC: begin
                     granted_in = idle_ff;
                     idle_in    = next_rd_ff;
                  end
                  MODE_DISCARD: begin
                     if (mark_ok) idle_in = next_rd_ff;
                  end
                  MODE_COMMIT: begin
                     if (prev_rd_ff > LAST_NODE) begin
                        status_in = STATUS_NO_IDLE;
                     end else begin
                        mark_in = prev_rd_ff;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         ST_LINK: begin
            if (out_free) begin
               // second pair: next[idle] = node, prev[after] = node
               next_we    = 1'b1;
               next_wa    = idle_ff[AW-1:0];
               next_wd    = node_ff;
               prev_we    = (next_rd_ff <= LAST_NODE);
               prev_wa    = next_rd_ff[AW-1:0];
               prev_wd    = node_ff;
               finish     = 1'b1;
               granted_in = NONE_IDX;
               status_in  = STATUS_OK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idle_ff      <= IDX_W'(1);
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idle_ff      <= idle_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      node_ff    <= node_in;
      err_ff     <= err_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_mark_is_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (mark_ff <= LAST_NODE))
      else $error("mark left the pool");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted_node != NONE_IDX) |-> (rsp_status == STATUS_OK))
      else $error("node granted with failing status");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted beat not sequenced");

   a_finish_sets_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("finished beat lost");

endmodule : node_pool_mark_release_allocator_core

`default_nettype wire

>>> test/pool_check_pkg.sv
// ============================================================================
// pool_check_pkg: expected-grant tracking for the node pool allocator
// Mirrors the forward/backward links, the mark and the idle head, works out
// the grant beat owed for every accepted request and checks response beats.
// ============================================================================
package pool_check_pkg;

   import npa_pkg::*;

   localparam int POOL = 1024;
   localparam int IDX_W = $clog2(POOL + 2);

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type NO_NODE = idx_type'(POOL + 1);

   typedef struct packed {
      idx_type    granted;
      status_type status;
   } grant_type;

   class pool_tracker;

      idx_type     fwd [POOL + 1];
      idx_type     back [POOL + 1];
      idx_type     mark;
      idx_type     idle;
      idx_type     handed_out [$];   // recent grants, used to pick release targets
      grant_type   owed_grants [$];
      int unsigned rsp_beats;
      int unsigned errors;

      function new();
         for (int i = 0; i <= POOL; i++) begin
            fwd[i]  = (i < POOL) ? idx_type'(i + 1) : NO_NODE;
            back[i] = (i == 0) ? NO_NODE : idx_type'(i - 1);
         end
         mark      = '0;
         idle      = idx_type'(1);
         rsp_beats = 0;
         errors    = 0;
      endfunction

      function bit in_pool(idx_type i);
         return i <= POOL;
      endfunction

      // apply one accepted request and queue the grant beat it owes
      function void note_request(mode_type m, idx_type n);
         grant_type g;
         idx_type   after;
         g.granted = NO_NODE;
         g.status  = STATUS_OK;
         case (m)
            MODE_ALLOC: begin
               if (!in_pool(idle)) begin
                  g.status = STATUS_NO_IDLE;
               end else begin
                  g.granted = idle;
                  handed_out.push_back(idle);
                  if (handed_out.size() > 64) void'(handed_out.pop_front());
                  idle = fwd[idle];
               end
            end
            MODE_RELEASE: begin
               if (n == 0 || !in_pool(n)) begin
                  g.status = STATUS_BAD_IDX;
               end else if (!in_pool(idle)) begin
                  g.status = STATUS_NO_IDLE;
               end else begin
                  after   = fwd[idle];
                  fwd[n]  = after;
                  back[n] = idle;
                  if (in_pool(after)) back[after] = n;
                  fwd[idle] = n;
               end
            end
            MODE_DISCARD: begin
               if (in_pool(mark)) idle = fwd[mark];
            end
            MODE_COMMIT: begin
               if (!in_pool(idle) || !in_pool(back[idle])) g.status = STATUS_NO_IDLE;
               else mark = back[idle];
            end
            default: begin
               g.status = STATUS_OK;
            end
         endcase
         owed_grants.push_back(g);
      endfunction

      task flag_mismatch(string what);
         errors++;
         $display("MISMATCH beat %0d: %s", rsp_beats, what);
      endtask

      task check_response(idx_type got_node, status_type got_status);
         grant_type w;
         rsp_beats++;
         if (owed_grants.size() == 0) begin
            flag_mismatch("response beat with no request outstanding");
            return;
         end
         w = owed_grants.pop_front();
         if (got_node !== w.granted)
            flag_mismatch($sformatf("granted_node %0d, wanted %0d", got_node, w.granted));
         if (got_status !== w.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", got_status, w.status));
      endtask

   endclass

endpackage : pool_check_pkg

>>> test/tb_node_pool_mark_release_allocator_core.sv
// ============================================================================
// tb_node_pool_mark_release_allocator_core: node pool allocator testbench
// Directed beats for the corner cases, a fill run that drains the pool, then
// random mixes under varying back-pressure; each response beat is checked
// against the grant worked out when its request beat was accepted.
// ============================================================================
module tb_node_pool_mark_release_allocator_core;

   timeunit 1ns;
   timeprecision 1ps;

   import npa_pkg::*;
   import pool_check_pkg::*;

   // generous: covers the clearing pass, the long hold and heavy stalling
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 8;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic [1:0] req_mode  = MODE_ALLOC;
   idx_type    req_node  = '0;
   logic       rsp_ready = 1'b0;

   wire        req_ready;
   wire        rsp_valid;
   idx_type    rsp_granted_node;
   status_type rsp_status;

   pool_tracker book = new();

   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;   // only the stimulus process reads this
   int unsigned rsp_stall_pct = 0;   // written with NBAs, read by the receiver
   int unsigned hold_asks     = 0;   // bumped once per long hold wanted
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;

   node_pool_mark_release_allocator_core #(
      .POOL_NODES (POOL)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_node (rsp_granted_node),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a stuck handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: checks each response beat taken at this edge, then picks
   // ready for the next one. A long hold is counted down here, so the
   // stimulus side only has to ask for it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_granted_node, rsp_status);
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one request beat and returns at the edge where it is taken.
   // Valid is left high on return, so a back-to-back beat needs no second
   // assignment to it in the same step.
   task send_beat(input mode_type m, input idx_type n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_node  <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(m, n);
   endtask

   // Mixed traffic: allocation most often, releases aimed mostly at nodes that
   // were handed out, and now and then a wild index to hit the range check.
   task random_beat();
      int unsigned pick;
      int unsigned sel;
      idx_type     n;
      pick = $urandom_range(99);
      n    = idx_type'($urandom_range(2047));   // ignored outside release
      if (pick < 45) begin
         send_beat(MODE_ALLOC, n);
      end else if (pick < 70) begin
         sel = $urandom_range(9);
         if (sel < 6 && book.handed_out.size() > 0)
            n = book.handed_out[$urandom_range(book.handed_out.size() - 1)];
         else if (sel < 9)
            n = idx_type'($urandom_range(POOL, 1));
         send_beat(MODE_RELEASE, n);
      end else if (pick < 82) begin
         send_beat(MODE_DISCARD, n);
      end else begin
         send_beat(MODE_COMMIT, n);
      end
   endtask

   // Sender goes quiet until every owed response beat is back. At least one
   // edge passes with valid low, so the next beat never re-raises it in
   // the same step.
   task wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed_grants.size() != 0) @(posedge clock);
   endtask

   task random_phase(input int unsigned beats, input int unsigned idle_pct,
                     input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      repeat (beats) random_beat();
      wait_quiet();
   endtask

   initial begin
      int      guard;
      idx_type n;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed, chain still in order --------------------------------
      // node field carries junk where it is ignored
      send_beat(MODE_ALLOC, '0);
      send_beat(MODE_ALLOC, idx_type'(POOL));
      send_beat(MODE_RELEASE, '0);             // sentinel refused
      send_beat(MODE_RELEASE, NO_NODE);        // just past the pool
      send_beat(MODE_RELEASE, '1);             // top of the field
      send_beat(MODE_RELEASE, idx_type'(1));   // allocated node back in
      send_beat(MODE_COMMIT, '1);
      send_beat(MODE_ALLOC, '0);
      send_beat(MODE_DISCARD, '1);

      // --- fill: allocate until the pool runs dry -------------------------
      // No discards or releases here, so the idle chain has no loop and
      // is bound to run out.
      guard = 0;
      while (book.in_pool(book.idle) && guard < 1200) begin
         guard++;
         n = idx_type'($urandom_range(2047));
         if ($urandom_range(99) < 4) send_beat(MODE_COMMIT, n);
         else send_beat(MODE_ALLOC, n);
      end

      // exhausted pool: every path that needs an idle head
      send_beat(MODE_ALLOC, '0);
      send_beat(MODE_RELEASE, idx_type'(5));   // no idle head
      send_beat(MODE_RELEASE, '0);             // bad index wins over no idle
      send_beat(MODE_COMMIT, '0);
      send_beat(MODE_DISCARD, '0);             // term returns to the pool
      wait_quiet();

      // --- random mixes, one idling pattern each -------------------------
      random_phase(130, 0, 0);
      random_phase(130, 70, 0);
      random_phase(130, 0, 70);
      random_phase(130, 30, 30);

      // --- pressure: receiver holds off, sender keeps offering ----------
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_asks <= hold_asks + 1;
      repeat (40) random_beat();
      wait_quiet();

      // --- directed, link writes that fold the chain back on itself ------
      if (book.in_pool(book.idle)) begin
         n = book.fwd[book.idle];
         if (n == 0 || !book.in_pool(n)) n = idx_type'(2);
         send_beat(MODE_RELEASE, n);                 // already on the idle chain
         send_beat(MODE_RELEASE, idx_type'(POOL));   // last pool node
         send_beat(MODE_RELEASE, book.idle);         // the idle head itself
      end else begin
         send_beat(MODE_RELEASE, idx_type'(POOL));
      end
      send_beat(MODE_ALLOC, '1);
      send_beat(MODE_ALLOC, '0);
      send_beat(MODE_COMMIT, '0);
      send_beat(MODE_DISCARD, '1);
      send_beat(MODE_ALLOC, '0);
      wait_quiet();

      // let any stray response beat show itself
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.owed_grants.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule : tb_node_pool_mark_release_allocator_core
